>>> rtl/range_expression_parser_top_assert.svh
// Assertion macros for the range expression parser.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RANGE_EXPRESSION_PARSER_TOP_ASSERT_SVH
`define RANGE_EXPRESSION_PARSER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define REP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define REP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rep_pkg.sv
// Shared constants and types for the range expression parser.
// No dependencies; used by rep_core and range_expression_parser_top.
package rep_pkg;

  localparam int unsigned MAX_LEN    = 4096;
  localparam int unsigned POS_W      = $clog2(MAX_LEN) + 1;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEXT_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_OPEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_CLOSE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_OPEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_CLOSE = 3'd5;

  typedef struct packed {
    logic [CHAR_W-1:0] range_char;
    logic [CHAR_W-1:0] next_range_char;
    logic [CHAR_W-1:0] step_open_char;
    logic [CHAR_W-1:0] step_close_char;
    logic [CHAR_W-1:0] skip_open_char;
    logic [CHAR_W-1:0] skip_close_char;
  } rep_cfg_t;

  localparam rep_cfg_t CFG_RESET = '{
    range_char:      8'd45,
    next_range_char: 8'd44,
    step_open_char:  8'd91,
    step_close_char: 8'd93,
    skip_open_char:  8'd123,
    skip_close_char: 8'd125
  };

  typedef struct packed {
    logic                  parse_ok;
    logic [POS_W-1:0]      fail_pos;
    logic [VALUE_BITS-1:0] first_value;
    logic [VALUE_BITS-1:0] last_value;
    logic [VALUE_BITS-1:0] step_value;
    logic                  has_end;
    logic                  has_step;
    logic                  has_skip;
    logic [POS_W-1:0]      skip_offset;
    logic [POS_W-1:0]      skip_length;
    logic [POS_W-1:0]      matched_length;
  } rep_result_t;

endpackage

>>> rtl/rep_core.sv
// Parser state and per-character next-state logic of the range expression parser.
// Depends on rep_pkg.
module rep_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    take_i,
  input  logic [7:0]              char_code_i,
  input  logic                    is_last_i,
  input  rep_pkg::rep_cfg_t       cfg_i,
  output rep_pkg::rep_result_t    res_o
);
  import rep_pkg::*;

  typedef enum logic [3:0] {
    PH_FIRST      = 4'd0,
    PH_START      = 4'd1,
    PH_END_FIRST  = 4'd2,
    PH_END        = 4'd3,
    PH_STEP_FIRST = 4'd4,
    PH_STEP       = 4'd5,
    PH_AFTER_STEP = 4'd6,
    PH_SKIP       = 4'd7,
    PH_OK         = 4'd8,
    PH_FAIL       = 4'd9
  } phase_e;

  typedef struct packed {
    phase_e                phase;
    logic [VALUE_BITS-1:0] start_acc;
    logic [VALUE_BITS-1:0] end_acc;
    logic [VALUE_BITS-1:0] step_acc;
    logic [POS_W-1:0]      depth;
    logic [POS_W-1:0]      skip_start;
    logic [POS_W-1:0]      skip_len;
    logic [POS_W-1:0]      stop_pos;
    logic                  has_end;
    logic                  has_step;
    logic                  has_skip;
  } pstate_t;

  localparam pstate_t ST_CLEAR = '{
    phase:      PH_FIRST,
    start_acc:  '0,
    end_acc:    '0,
    step_acc:   '0,
    depth:      '0,
    skip_start: '0,
    skip_len:   '0,
    stop_pos:   '0,
    has_end:    1'b0,
    has_step:   1'b0,
    has_skip:   1'b0
  };

  // acc * 10 + d, saturating at the all-ones value.
  function automatic logic [VALUE_BITS-1:0] acc_digit(input logic [VALUE_BITS-1:0] acc,
                                                      input logic [3:0] d);
    logic [VALUE_BITS+3:0] prod;
    prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{VALUE_BITS{1'b0}}, d};
    if (prod[VALUE_BITS+3:VALUE_BITS] != 4'b0) begin
      return {VALUE_BITS{1'b1}};
    end
    return prod[VALUE_BITS-1:0];
  endfunction

  // One parser step. The end of the string is fed in as a virtual NUL.
  function automatic pstate_t take(input pstate_t s, input logic [7:0] c,
                                   input logic [POS_W-1:0] p, input logic virt,
                                   input logic [VALUE_BITS-1:0] mac, input rep_cfg_t cfg);
    pstate_t                n;
    logic                   dig;
    logic [POS_W-1:0]       p1;
    logic [VALUE_BITS-1:0]  d0;
    n   = s;
    dig = !virt && (c >= 8'd48) && (c <= 8'd57);
    p1  = p + 1'b1;
    d0  = VALUE_BITS'(c[3:0]);
    unique case (s.phase)
      PH_FIRST: begin
        if (dig) begin
          n.start_acc = d0;
          n.phase     = PH_START;
        end else begin
          n.phase    = PH_FAIL;
          n.stop_pos = '0;
        end
      end
      PH_START: begin
        if (dig) begin
          n.start_acc = mac;
        end else if (virt) begin
          n.phase = PH_OK;  n.stop_pos = p;
        end else if (c == cfg.range_char) begin
          n.phase = PH_END_FIRST;
        end else if (c == cfg.next_range_char) begin
          n.phase = PH_OK;  n.stop_pos = p;
        end else begin
          n.phase = PH_FAIL;  n.stop_pos = p;
        end
      end
      PH_END_FIRST: begin
        if (dig) begin
          n.end_acc = d0;
          n.has_end = 1'b1;
          n.phase   = PH_END;
        end else begin
          n.phase = PH_FAIL;  n.stop_pos = p;
        end
      end
      PH_END: begin
        if (dig) begin
          n.end_acc = mac;
        end else if (virt) begin
          n.phase = PH_OK;  n.stop_pos = p;
        end else if (c == cfg.step_open_char) begin
          n.phase = PH_STEP_FIRST;
        end else if (c == cfg.skip_open_char) begin
          n.skip_start = p1;
          n.depth      = '0;
          n.phase      = PH_SKIP;
        end else begin
          n.phase = PH_OK;  n.stop_pos = p;
        end
      end
      PH_STEP_FIRST: begin
        if (dig) begin
          n.step_acc = d0;
          n.phase    = PH_STEP;
        end else begin
          n.phase = PH_FAIL;  n.stop_pos = p;
        end
      end
      PH_STEP: begin
        if (dig) begin
          n.step_acc = mac;
        end else if (c == cfg.step_close_char) begin
          n.has_step = 1'b1;
          if (virt) begin
            n.phase = PH_OK;  n.stop_pos = p1;
          end else begin
            n.phase = PH_AFTER_STEP;
          end
        end else begin
          n.phase = PH_FAIL;  n.stop_pos = p;
        end
      end
      PH_AFTER_STEP: begin
        if (!virt && (c == cfg.skip_open_char)) begin
          n.skip_start = p1;
          n.depth      = '0;
          n.phase      = PH_SKIP;
        end else begin
          n.phase = PH_OK;  n.stop_pos = p;
        end
      end
      PH_SKIP: begin
        if (!virt && (c == cfg.skip_open_char)) begin
          if (s.depth < POS_W'(MAX_LEN)) begin
            n.depth = s.depth + 1'b1;
          end
        end else if (c == cfg.skip_close_char) begin
          if (!virt && (s.depth != '0)) begin
            n.depth = s.depth - 1'b1;
          end else begin
            n.skip_len = (p >= s.skip_start) ? (p - s.skip_start) : '0;
            n.has_skip = 1'b1;
            n.phase    = PH_OK;
            n.stop_pos = p1;
          end
        end else if (virt) begin
          n.phase = PH_FAIL;  n.stop_pos = p;
        end
      end
      default: begin
        // Decision made: later characters are ignored.
      end
    endcase
    return n;
  endfunction

  pstate_t               st_q, st_real, st_end;
  logic [POS_W-1:0]      pos_q, pos_inc;
  logic [VALUE_BITS-1:0] acc_sel, mac;
  logic                  ok;

  // One shared multiply-by-ten: only the accumulator of the current phase grows.
  always_comb begin
    case (st_q.phase)
      PH_END:  acc_sel = st_q.end_acc;
      PH_STEP: acc_sel = st_q.step_acc;
      default: acc_sel = st_q.start_acc;
    endcase
    mac     = acc_digit(acc_sel, char_code_i[3:0]);
    pos_inc = (pos_q < POS_W'(MAX_LEN)) ? (pos_q + 1'b1) : pos_q;
    st_real = take(st_q, char_code_i, pos_q, 1'b0, mac, cfg_i);
    st_end  = take(st_real, 8'd0, pos_inc, 1'b1, mac, cfg_i);
  end

  assign ok = (st_end.phase == PH_OK);

  always_comb begin
    res_o.parse_ok       = ok;
    res_o.fail_pos       = ok ? '0 : st_end.stop_pos;
    res_o.first_value    = st_end.start_acc;
    res_o.last_value     = st_end.has_end ? st_end.end_acc : '0;
    res_o.step_value     = st_end.has_step ? st_end.step_acc : '0;
    res_o.has_end        = st_end.has_end;
    res_o.has_step       = st_end.has_step;
    res_o.has_skip       = st_end.has_skip;
    res_o.skip_offset    = st_end.has_skip ? st_end.skip_start : '0;
    res_o.skip_length    = st_end.has_skip ? st_end.skip_len : '0;
    res_o.matched_length = ok ? st_end.stop_pos : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_CLEAR;
      pos_q <= '0;
    end else if (take_i) begin
      if (is_last_i) begin
        st_q  <= ST_CLEAR;
        pos_q <= '0;
      end else begin
        st_q  <= st_real;
        pos_q <= pos_inc;
      end
    end
  end

endmodule

>>> rtl/range_expression_parser_top.sv
// Top level of the range expression parser: configuration registers,
// result register and handshakes. Depends on rep_pkg, rep_core and the assertion header.
//
// Usage: the string start[-end[[inc]][{exclude}]] is sent one character per
// item on the input channel (char_code_i, is_last_i) with valid/ready. The
// separator and bracket characters come from six 8-bit registers written
// through cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is idle.
// Throughput is one character per cycle. Each character is folded into the
// parser state in the cycle it is accepted; the multiply-by-ten of the
// decimal accumulators sits in that same cycle. When the item that carries
// is_last is accepted, the end-of-string step is evaluated as well and the
// result item appears on the output channel in the next cycle.
// The result waits in a single output register. While it waits, characters
// that are not the last one keep being accepted; only a last item stalls
// (in_ready_o low) until the receiver takes the pending result.
// Reset clears the parser, empties the output register and restores the
// default characters '-', ',', '[', ']', '{' and '}'. No clearing pass is needed.
`include "range_expression_parser_top_assert.svh"

module range_expression_parser_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rep_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rep_pkg::CHAR_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rep_pkg::CHAR_W-1:0]       char_code_i,
  input  logic                             is_last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             parse_ok_o,
  output logic [rep_pkg::POS_W-1:0]        fail_pos_o,
  output logic [rep_pkg::VALUE_BITS-1:0]   first_value_o,
  output logic [rep_pkg::VALUE_BITS-1:0]   last_value_o,
  output logic [rep_pkg::VALUE_BITS-1:0]   step_value_o,
  output logic                             has_end_o,
  output logic                             has_step_o,
  output logic                             has_skip_o,
  output logic [rep_pkg::POS_W-1:0]        skip_offset_o,
  output logic [rep_pkg::POS_W-1:0]        skip_length_o,
  output logic [rep_pkg::POS_W-1:0]        matched_length_o
);
  import rep_pkg::*;

  rep_cfg_t    cfg_q;
  rep_result_t res_d, res_q;
  logic        out_valid_q;
  logic        in_fire;

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RANGE:      cfg_q.range_char      <= cfg_wdata_i;
        CFG_NEXT_RANGE: cfg_q.next_range_char <= cfg_wdata_i;
        CFG_STEP_OPEN:  cfg_q.step_open_char  <= cfg_wdata_i;
        CFG_STEP_CLOSE: cfg_q.step_close_char <= cfg_wdata_i;
        CFG_SKIP_OPEN:  cfg_q.skip_open_char  <= cfg_wdata_i;
        CFG_SKIP_CLOSE: cfg_q.skip_close_char <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Only a last character needs room in the output register.
  assign in_ready_o = !out_valid_q || out_ready_i || !is_last_i;
  assign in_fire    = in_valid_i && in_ready_o;

  rep_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (in_fire),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .cfg_i       (cfg_q),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && is_last_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: loaded only when a string completes.
  always_ff @(posedge clk_i) begin
    if (in_fire && is_last_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign parse_ok_o       = res_q.parse_ok;
  assign fail_pos_o       = res_q.fail_pos;
  assign first_value_o    = res_q.first_value;
  assign last_value_o     = res_q.last_value;
  assign step_value_o     = res_q.step_value;
  assign has_end_o        = res_q.has_end;
  assign has_step_o       = res_q.has_step;
  assign has_skip_o       = res_q.has_skip;
  assign skip_offset_o    = res_q.skip_offset;
  assign skip_length_o    = res_q.skip_length;
  assign matched_length_o = res_q.matched_length;

  // The input stalls only for a last character behind an untaken result.
  `REP_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_q && !out_ready_i && is_last_i, "input stalled without a pending result")
  // A completed string always produces a result in the next cycle.
  `REP_ASSERT_NEXT(a_result_follows, in_fire && is_last_i, out_valid_o, "missing result after last character")
  // A success never reports a failing position, and a failure matches nothing.
  `REP_ASSERT_NOW(a_ok_fields, out_valid_o, parse_ok_o ? (fail_pos_o == '0) : (matched_length_o == '0), "inconsistent success fields")
  // An increment part only exists after an end value.
  `REP_ASSERT_NOW(a_step_needs_end, out_valid_o && has_step_o, has_end_o, "step found without end")
  // Without an exclude part its offset and length stay zero.
  `REP_ASSERT_NOW(a_skip_fields, out_valid_o && !has_skip_o, (skip_offset_o == '0) && (skip_length_o == '0), "exclude fields set without exclude part")

endmodule
